### rtl/tmsa_pkg.sv
// tmsa_pkg: types, constants and state encodings for tm_score_accumulator.
// No dependencies; imported by every module of the block.
package tmsa_pkg;

    localparam int COORD_W       = 24;
    localparam int ROT_W         = 16;
    localparam int ROW_W         = 48;
    localparam int LEN_W         = 13;
    localparam int SUM_W         = 28;
    localparam int PAIRS_W       = 13;
    localparam int TERM_W        = 17;
    localparam int D0SQ_W        = 27;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 48;
    localparam int DEF_MAX_PAIRS = 4096;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = 2;

    localparam logic [D0SQ_W-1:0] D0SQ_SHORT    = 27'd61409;
    localparam logic [LEN_W-1:0]  LEN_SHORT_MAX = 13'd19;
    localparam logic [LEN_W-1:0]  LEN_OFFSET    = 13'd15;
    localparam logic [16:0]       C124_Q16      = 17'd81265;
    localparam logic [SUM_W-1:0]  SUM_MAX       = 28'hFFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT0 = 3'd0,
        CFG_ROT1 = 3'd1,
        CFG_ROT2 = 3'd2,
        CFG_TX   = 3'd3,
        CFG_TY   = 3'd4,
        CFG_TZ   = 3'd5,
        CFG_LEN  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic signed [COORD_W-1:0] qz;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] tz;
        logic                      last;
    } pair_t;

    typedef struct packed {
        logic [ROW_W-1:0]          row0;
        logic [ROW_W-1:0]          row1;
        logic [ROW_W-1:0]          row2;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] tz;
    } xform_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROT,
        B_MOVE,
        B_SQ,
        B_DEN,
        B_DIV,
        B_ACC
    } back_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL,
        C_CMP,
        C_SCALE,
        C_OFFS,
        C_SQ,
        C_ROUND
    } cbrt_state_t;

endpackage

### rtl/tmsa_d0sq.sv
// tmsa_d0sq: d0 squared from the normalizing length (a constant up to length 19), bitwise cube root
// (a multiply state and a compare state per root bit) followed by scale, offset and squaring. Uses tmsa_pkg.
module tmsa_d0sq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tmsa_pkg::LEN_W-1:0]   len,
    output logic                         busy,
    output logic [tmsa_pkg::D0SQ_W-1:0]  d0sq
);
    import tmsa_pkg::*;

    cbrt_state_t state_reg, state_next;

    logic [60:0]        x_reg;
    logic [20:0]        y_reg;
    logic [4:0]         k_reg;
    logic [42:0]        p_reg;
    logic [37:0]        w_reg;
    logic [21:0]        d0_reg;
    logic [43:0]        sqd_reg;
    logic [D0SQ_W-1:0]  d0sq_reg;

    logic [20:0]        y2;
    logic [44:0]        t;
    logic [5:0]         shamt;
    logic [60:0]        xs;
    logic               take;
    logic [22:0]        w_rnd;

    assign y2    = {y_reg[19:0], 1'b0};
    assign t     = 45'(p_reg) + 45'(p_reg) + 45'(p_reg) + 45'd1;
    assign shamt = 6'(k_reg) + 6'(k_reg) + 6'(k_reg);
    assign xs    = x_reg >> shamt;
    assign take  = ({17'b0, xs} >= {33'b0, t}) ? 1'b1 : 1'b0;
    assign w_rnd = 23'((39'(w_reg) + 39'd32768) >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            d0sq_reg  <= D0SQ_SHORT;
        end
        else
        begin
            state_reg <= state_next;
            if (start && len <= LEN_SHORT_MAX)
                d0sq_reg <= D0SQ_SHORT;
            else if (state_reg == C_ROUND)
                d0sq_reg <= D0SQ_W'((45'(sqd_reg) + 45'd32768) >> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                x_reg <= {48'(len - LEN_OFFSET), 13'b0} << 35;
                y_reg <= '0;
                k_reg <= 5'd20;
            end
            C_MUL:
            begin
                p_reg <= 43'(y2 * {1'b0, y2 + 21'd1});
                y_reg <= y2;
            end
            C_CMP:
            begin
                if (take)
                begin
                    x_reg <= x_reg - (61'(t) << shamt);
                    y_reg <= y_reg + 21'd1;
                end
                k_reg <= k_reg - 5'd1;
            end
            C_SCALE: w_reg   <= 38'(C124_Q16 * y_reg);
            C_OFFS:  d0_reg  <= 22'(w_rnd - 23'd65536);
            C_SQ:    sqd_reg <= d0_reg * d0_reg;
            C_ROUND: ;
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:  if (start && len > LEN_SHORT_MAX) state_next = C_MUL;
            C_MUL:   state_next = C_CMP;
            C_CMP:   state_next = (k_reg == 5'd0) ? C_SCALE : C_MUL;
            C_SCALE: state_next = C_OFFS;
            C_OFFS:  state_next = C_SQ;
            C_SQ:    state_next = C_ROUND;
            C_ROUND: state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    assign busy = (state_reg != C_IDLE);
    assign d0sq = d0sq_reg;

endmodule

### rtl/tmsa_front.sv
// tmsa_front: accepts input items into a short queue feeding the back end.
// Uses tmsa_pkg (pair_t, queue depth).
module tmsa_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tmsa_pkg::pair_t in_item,
    input  logic            hold,
    output logic            q_valid,
    input  logic            q_ready,
    output tmsa_pkg::pair_t q_item
);
    import tmsa_pkg::*;

    pair_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push, pop;

    assign in_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH)) && !hold;
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_item   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/tmsa_back.sv
// tmsa_back: superposition, squared distance, 17-step term divider, saturating
// accumulation and output register. Uses tmsa_pkg.
module tmsa_back #(
    parameter int MAX_PAIRS = tmsa_pkg::DEF_MAX_PAIRS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  tmsa_pkg::pair_t              q_item,
    input  tmsa_pkg::xform_t             xf,
    input  logic [tmsa_pkg::D0SQ_W-1:0]  d0sq,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tmsa_pkg::SUM_W-1:0]   out_score,
    output logic [tmsa_pkg::PAIRS_W-1:0] out_pairs
);
    import tmsa_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int DEN_W = 62;
    localparam int REM_W = 63;
    localparam int DSH_W = DEN_W + TERM_W;

    back_state_t state_reg, state_next;

    pair_t                   item_reg;
    logic signed [39:0]      prod_reg [9];
    logic signed [29:0]      diff_reg [3];
    logic [58:0]             sq_reg [3];
    logic [REM_W-1:0]        rem_reg;
    logic [DSH_W-1:0]        dsh_reg;
    logic [TERM_W-1:0]       quo_reg;
    logic [4:0]              bit_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    out_valid_reg;
    logic [SUM_W-1:0]        out_score_reg;
    logic [PAIRS_W-1:0]      out_pairs_reg;

    logic [ROW_W-1:0]          rows [3];
    logic signed [COORD_W-1:0] tgt [3];
    logic signed [COORD_W-1:0] qry [3];
    logic signed [COORD_W-1:0] trn [3];
    logic signed [29:0]        diff [3];
    logic signed [41:0]        acc;
    logic signed [28:0]        moved;
    logic [60:0]               di;
    logic [DEN_W-1:0]          den;
    logic                      ge;
    logic [SUM_W:0]            sum_w;
    logic [SUM_W-1:0]          sum_sat;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      out_load;

    assign rows = '{xf.row0, xf.row1, xf.row2};
    assign tgt  = '{item_reg.tx, item_reg.ty, item_reg.tz};
    assign qry  = '{item_reg.qx, item_reg.qy, item_reg.qz};
    assign trn  = '{xf.tx, xf.ty, xf.tz};

    always_comb
    begin
        acc   = '0;
        moved = '0;
        for (int r = 0; r < 3; r++)
        begin
            acc = 42'(prod_reg[3*r]) + 42'(prod_reg[3*r+1]) + 42'(prod_reg[3*r+2])
                  + 42'sd8192;
            moved = 29'(acc >>> 14) + 29'(trn[r]);
            diff[r] = 30'(qry[r]) - 30'(moved);
        end
    end

    assign di      = 61'(sq_reg[0]) + 61'(sq_reg[1]) + 61'(sq_reg[2]);
    assign den     = DEN_W'(di) + DEN_W'(d0sq);
    assign ge      = (DSH_W'(rem_reg) >= dsh_reg);
    assign sum_w   = {1'b0, sum_reg} + (SUM_W+1)'(quo_reg);
    assign sum_sat = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
    assign cnt_inc = (cnt_reg < CNT_W'(MAX_PAIRS)) ? cnt_reg + 1'b1 : cnt_reg;
    assign out_load = (state_reg == B_ACC) && item_reg.last
                      && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE: item_reg <= q_item;
            B_ROT:
            begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        prod_reg[3*r+c] <= $signed(rows[r][ROT_W*c +: ROT_W]) * tgt[c];
            end
            B_MOVE: diff_reg <= diff;
            B_SQ:
            begin
                for (int r = 0; r < 3; r++)
                    sq_reg[r] <= 59'(diff_reg[r] * diff_reg[r]);
            end
            B_DEN:
            begin
                rem_reg <= REM_W'({d0sq, 16'b0}) + REM_W'(den >> 1);
                dsh_reg <= DSH_W'(den) << (TERM_W - 1);
                quo_reg <= '0;
                bit_reg <= 5'(TERM_W - 1);
            end
            B_DIV:
            begin
                if (ge)
                    rem_reg <= rem_reg - REM_W'(dsh_reg);
                quo_reg <= {quo_reg[TERM_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                bit_reg <= bit_reg - 5'd1;
            end
            B_ACC: ;
            default: ;
        endcase
        if (out_load)
        begin
            out_score_reg <= sum_sat;
            out_pairs_reg <= PAIRS_W'(cnt_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else if (state_reg == B_ACC && !item_reg.last)
            begin
                sum_reg <= sum_sat;
                cnt_reg <= cnt_inc;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (q_valid) state_next = B_ROT;
            B_ROT:  state_next = B_MOVE;
            B_MOVE: state_next = B_SQ;
            B_SQ:   state_next = B_DEN;
            B_DEN:  state_next = B_DIV;
            B_DIV:  if (bit_reg == 5'd0) state_next = B_ACC;
            B_ACC:  if (!item_reg.last || out_load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    assign q_ready   = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign out_score = out_score_reg;
    assign out_pairs = out_pairs_reg;

endmodule

### rtl/tm_score_accumulator.sv
// tm_score_accumulator: top level, configuration registers, queue front end,
// compute back end and d0 squared unit. Uses tmsa_pkg, tmsa_front, tmsa_back, tmsa_d0sq.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: pair coordinates, tlast: last_pair
//  m_*      out  tvalid/tready      tdata: score_sum, pairs_seen
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// The back end works on one pair at a time, mostly in its 17-step term divider.
// A four-entry queue keeps taking items, until full, while the back end works or stalls.
// A norm_length write above 19 starts a cube-root pass; s_tready is low during it.
// Reset: sum and count cleared, zero transform, d0 squared for length 1.
module tm_score_accumulator #(
    parameter int MAX_PAIRS = tmsa_pkg::DEF_MAX_PAIRS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // query_x, query_y, query_z, target_x, target_y, target_z
    input  logic [6*tmsa_pkg::COORD_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // score_sum, pairs_seen, zero fill
    output logic [47:0]                         m_tdata,
    input  logic                                cfg_we,
    input  logic [tmsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tmsa_pkg::*;

    xform_t             xf_reg;
    pair_t              in_item, q_item;
    logic               q_valid, q_ready, busy, len_wr;
    logic [D0SQ_W-1:0]  d0sq;
    logic [SUM_W-1:0]   score;
    logic [PAIRS_W-1:0] pairs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xf_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROT0: xf_reg.row0 <= cfg_data;
                CFG_ROT1: xf_reg.row1 <= cfg_data;
                CFG_ROT2: xf_reg.row2 <= cfg_data;
                CFG_TX:   xf_reg.tx   <= cfg_data[COORD_W-1:0];
                CFG_TY:   xf_reg.ty   <= cfg_data[COORD_W-1:0];
                CFG_TZ:   xf_reg.tz   <= cfg_data[COORD_W-1:0];
                CFG_LEN:  ;
                default:  ;
            endcase
        end
    end

    assign len_wr = cfg_we && (cfg_idx_t'(cfg_index) == CFG_LEN);

    assign in_item.qx   = s_tdata[0*COORD_W +: COORD_W];
    assign in_item.qy   = s_tdata[1*COORD_W +: COORD_W];
    assign in_item.qz   = s_tdata[2*COORD_W +: COORD_W];
    assign in_item.tx   = s_tdata[3*COORD_W +: COORD_W];
    assign in_item.ty   = s_tdata[4*COORD_W +: COORD_W];
    assign in_item.tz   = s_tdata[5*COORD_W +: COORD_W];
    assign in_item.last = s_tlast;

    tmsa_d0sq u_d0sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (len_wr),
        .len   (cfg_data[LEN_W-1:0]),
        .busy  (busy),
        .d0sq  (d0sq)
    );

    tmsa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .hold     (busy),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    tmsa_back #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .xf        (xf_reg),
        .d0sq      (d0sq),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_score (score),
        .out_pairs (pairs)
    );

    assign m_tdata = {7'b0, pairs, score};

endmodule

### tb/tb.sv
// Testbench for tm_score_accumulator: streams aligned point pairs under several transforms
// and lengths, predicts each run's score sum and pair count, and checks every result item.
// Depends on tmsa_pkg and the tm_score_accumulator RTL.
module tb;
    import tmsa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int SETTLE_CYC = 200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [15:0] ONE_Q14 = 16'h4000;

    typedef enum logic [1:0] {K_PAIR, K_CFG, K_WAIT} job_kind_t;

    typedef struct {
        job_kind_t              kind;
        pair_t                  pair;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
    } job_t;

    typedef struct {
        logic [SUM_W-1:0]   sum;
        logic [PAIRS_W-1:0] pairs;
    } score_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [6*COORD_W-1:0] s_tdata = '0;
    logic s_tlast = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tm_score_accumulator dut (.*);

    job_t   pending[$];
    score_t scores_due[$];
    pair_t  cur_pair;
    int     errors = 0;
    int     cycles = 0;
    int     in_gap = 0;
    int     out_gap = 0;
    int     settle = 0;
    int     results = 0;
    int     hold_cnt = 0;
    bit     hold_done = 0;
    bit     quiet = 0;

    logic [ROW_W-1:0]   m_row[3];
    longint             m_trans[3];
    logic [LEN_W-1:0]   m_len;
    logic [63:0]        m_d0sq;
    logic [SUM_W-1:0]   acc_sum;
    logic [PAIRS_W-1:0] acc_pairs;

    initial forever #5 clk = ~clk;

    function automatic logic [63:0] d0sq_for(logic [LEN_W-1:0] len);
        logic [63:0] d0, lo, hi, mid, v;
        if (len <= 19)
            d0 = 64'd63439;
        else
        begin
            v = 64'(len - 15) << 48;
            lo = '0;
            hi = 64'd1 << 21;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) >> 1;
                if (mid * mid * mid <= v)
                    lo = mid;
                else
                    hi = mid;
            end
            d0 = ((64'd81265 * lo + 64'd32768) >> 16) - 64'd65536;
        end
        return (d0 * d0 + 64'd32768) >> 16;
    endfunction

    function automatic longint move_axis(logic [ROW_W-1:0] row, longint x, longint y,
                                         longint z, longint t);
        longint s;
        s = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
            + longint'($signed(row[47:32])) * z;
        return ((s + 8192) >>> 14) + t;
    endfunction

    task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_ROT0: m_row[0] = d;
            CFG_ROT1: m_row[1] = d;
            CFG_ROT2: m_row[2] = d;
            CFG_TX:   m_trans[0] = longint'($signed(d[23:0]));
            CFG_TY:   m_trans[1] = longint'($signed(d[23:0]));
            CFG_TZ:   m_trans[2] = longint'($signed(d[23:0]));
            CFG_LEN:
            begin
                m_len = d[LEN_W-1:0];
                m_d0sq = d0sq_for(m_len);
            end
            default: ;
        endcase
    endtask

    task automatic score_pair(pair_t p);
        longint q[3], m[3], dlt;
        logic [63:0] di, den, term, s;
        score_t r;
        q[0] = longint'(p.qx); q[1] = longint'(p.qy); q[2] = longint'(p.qz);
        di = '0;
        for (int a = 0; a < 3; a++)
        begin
            m[a] = move_axis(m_row[a], longint'(p.tx), longint'(p.ty), longint'(p.tz),
                             m_trans[a]);
            dlt = q[a] - m[a];
            if (dlt < 0)
                dlt = -dlt;
            di += 64'(dlt) * 64'(dlt);
        end
        den = m_d0sq + di;
        term = ((m_d0sq << 16) + (den >> 1)) / den;
        s = 64'(acc_sum) + term;
        acc_sum = (s > 64'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
        if (acc_pairs < DEF_MAX_PAIRS)
            acc_pairs++;
        if (p.last)
        begin
            r.sum = acc_sum;
            r.pairs = acc_pairs;
            scores_due.insert(scores_due.size(), r);
            acc_sum = '0;
            acc_pairs = '0;
        end
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        job_t j;
        j.kind = K_CFG;
        j.idx = idx;
        j.data = d;
        j.pair = '0;
        pending.insert(pending.size(), j);
    endtask

    task automatic add_pair(int qx, int qy, int qz, int tx, int ty, int tz, bit last);
        job_t j;
        j.kind = K_PAIR;
        j.idx = '0;
        j.data = '0;
        j.pair.qx = 24'(qx); j.pair.qy = 24'(qy); j.pair.qz = 24'(qz);
        j.pair.tx = 24'(tx); j.pair.ty = 24'(ty); j.pair.tz = 24'(tz);
        j.pair.last = last;
        pending.insert(pending.size(), j);
    endtask

    task automatic add_wait();
        job_t j;
        j.kind = K_WAIT;
        j.idx = '0;
        j.data = '0;
        j.pair = '0;
        pending.insert(pending.size(), j);
    endtask

    function automatic logic [ROW_W-1:0] rand_row(int axis);
        logic [ROW_W-1:0] r;
        case ($urandom_range(0, 3))
            0: r = 48'({$urandom, $urandom});
            1:
            begin
                r = '0;
                r[axis*16 +: 16] = ONE_Q14;
            end
            2: r = {16'h8000, 16'h8000, 16'h8000};
            default:
            begin
                r = {3{16'($urandom_range(0, 255) - 128)}};
                r[axis*16 +: 16] = ONE_Q14 + 16'($urandom_range(0, 511) - 256);
            end
        endcase
        return r;
    endfunction

    task automatic add_setting(bit wide);
        logic [CFG_DATA_W-1:0] t;
        for (int a = 0; a < 3; a++)
            add_cfg(CFG_IDX_W'(CFG_ROT0 + a), wide ? rand_row(a) : 48'(ONE_Q14) << (16 * a));
        for (int a = 0; a < 3; a++)
        begin
            t = wide ? 48'($urandom) : 48'($urandom_range(0, 2047) - 1024);
            add_cfg(CFG_IDX_W'(CFG_TX + a), t);
        end
        case ($urandom_range(0, 4))
            0: add_cfg(CFG_LEN, 48'($urandom_range(0, 19)));
            1: add_cfg(CFG_LEN, 48'($urandom_range(4000, 8191)));
            default: add_cfg(CFG_LEN, 48'($urandom_range(20, 600)));
        endcase
    endtask

    function automatic int rand_coord(bit wide, int base);
        if (wide || $urandom_range(0, 9) == 0)
            return $signed(24'($urandom));
        return base + $urandom_range(0, 4095) - 2048;
    endfunction

    initial
    begin
        int n, runlen, qx, qy, qz;
        bit wide;
        m_row[0] = '0; m_row[1] = '0; m_row[2] = '0;
        m_trans[0] = 0; m_trans[1] = 0; m_trans[2] = 0;
        m_len = LEN_W'(1);
        m_d0sq = d0sq_for(LEN_W'(1));
        acc_sum = '0;
        acc_pairs = '0;

        // directed: zero transform, then identity, extremes and lengths
        add_pair(0, 0, 0, 8388607, -8388608, 8388607, 1);
        add_pair(8388607, 8388607, 8388607, 0, 0, 0, 0);
        add_pair(-8388608, -8388608, -8388608, 0, 0, 0, 1);
        add_cfg(CFG_ROT0, 48'(ONE_Q14));
        add_cfg(CFG_ROT1, 48'(ONE_Q14) << 16);
        add_cfg(CFG_ROT2, 48'(ONE_Q14) << 32);
        add_cfg(CFG_SPARE, '1);
        add_pair(100, -200, 300, 100, -200, 300, 1);
        add_pair(8388607, -8388608, 8388607, 8388607, -8388608, 8388607, 0);
        add_pair(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607, 1);
        add_cfg(CFG_ROT0, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        add_cfg(CFG_ROT1, {16'h8000, 16'h8000, 16'h8000});
        add_cfg(CFG_ROT2, {16'h8000, 16'h7FFF, 16'h0000});
        add_cfg(CFG_TX, 48'h7FFFFF);
        add_cfg(CFG_TY, 48'h800000);
        add_cfg(CFG_TZ, 48'hFFFFFF);
        add_cfg(CFG_LEN, '0);
        add_pair(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 0);
        add_pair(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 1);
        add_cfg(CFG_LEN, 48'd20);
        add_pair(1, 2, 3, 4, 5, 6, 1);
        add_cfg(CFG_LEN, 48'd8191);
        add_pair(-1, -2, -3, 7, 8, 9, 1);
        add_cfg(CFG_LEN, 48'd4096);

        // longer run of exact matches under the identity
        add_setting(0);
        add_cfg(CFG_TX, '0); add_cfg(CFG_TY, '0); add_cfg(CFG_TZ, '0);
        add_cfg(CFG_LEN, 48'd19);
        for (int i = 0; i < 48; i++)
            add_pair(i, -i, 2 * i, i, -i, 2 * i, i == 47);

        // random runs with occasional new settings
        n = 0;
        while (n < 340)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                wide = $urandom_range(0, 3) == 0;
                add_setting(wide);
            end
            else if ($urandom_range(0, 9) == 0)
                add_wait();
            wide = $urandom_range(0, 4) == 0;
            runlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            for (int i = 0; i < runlen; i++)
            begin
                qx = rand_coord(1, 0);
                qy = rand_coord(1, 0);
                qz = rand_coord(1, 0);
                if (!wide)
                begin
                    qx = qx >>> 6; qy = qy >>> 6; qz = qz >>> 6;
                end
                add_pair(qx, qy, qz, rand_coord(wide, qx), rand_coord(wide, qy),
                         rand_coord(wide, qz), (i == runlen - 1) || ($urandom_range(0, 29) == 0));
                n++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1;
        do
            @(negedge clk);
        while (pending.size() != 0 || s_tvalid || scores_due.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
        if (errors == 0 && scores_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // driver
    always @(posedge clk)
    begin
        bit acc, nv, we;
        if (rst_n)
        begin
            acc = s_tvalid && s_tready;
            nv = s_tvalid && !acc;
            we = 0;
            if (acc)
            begin
                score_pair(cur_pair);
                if (!quiet && $urandom_range(0, 3) == 0)
                    in_gap = $urandom_range(1, 14);
            end
            quiet = pending.size() < 60;
            if (!nv)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending.size() > 0)
                begin
                    case (pending[0].kind)
                        K_PAIR:
                        begin
                            cur_pair = pending[0].pair;
                            s_tdata <= {cur_pair.tz, cur_pair.ty, cur_pair.tx,
                                        cur_pair.qz, cur_pair.qy, cur_pair.qx};
                            s_tlast <= cur_pair.last;
                            nv = 1;
                            void'(pending.pop_front());
                        end
                        K_WAIT:
                            if (scores_due.size() == 0)
                                void'(pending.pop_front());
                        default:
                            if (scores_due.size() != 0 || acc)
                                settle = 0;
                            else if (++settle >= SETTLE_CYC)
                            begin
                                settle = 0;
                                we = 1;
                                cfg_index <= pending[0].idx;
                                cfg_data <= pending[0].data;
                                apply_cfg(pending[0].idx, pending[0].data);
                                void'(pending.pop_front());
                            end
                    endcase
                end
            end
            s_tvalid <= nv;
            cfg_we <= we;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        score_t e;
        bit rdy;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results++;
                if (scores_due.size() == 0)
                begin
                    $error("unexpected result item %h", m_tdata);
                    errors++;
                end
                else
                begin
                    e = scores_due.pop_front();
                    if (m_tdata[27:0] !== e.sum)
                    begin
                        $error("score_sum expected %0d actual %0d", e.sum, m_tdata[27:0]);
                        errors++;
                    end
                    if (m_tdata[40:28] !== e.pairs)
                    begin
                        $error("pairs_seen expected %0d actual %0d", e.pairs, m_tdata[40:28]);
                        errors++;
                    end
                end
                if (!quiet && $urandom_range(0, 2) == 0)
                    out_gap = $urandom_range(1, 14);
            end
            if (!hold_done && results == 20)
            begin
                hold_done = 1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                rdy = 0;
            end
            else
                rdy = 1;
            m_tready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end
endmodule

### sim.f
rtl/tmsa_pkg.sv
rtl/tmsa_d0sq.sv
rtl/tmsa_front.sv
rtl/tmsa_back.sv
rtl/tm_score_accumulator.sv
tb/tb.sv
